// ===== rtl/ktl_pkg.sv =====
package ktl_pkg;

  localparam logic [23:0] LINE_MAX  = 24'hFFFFFF;
  localparam logic [15:0] COL_MAX   = 16'hFFFF;
  localparam logic [34:0] CONST_MAX = 35'd2147483647;
  localparam int          NUM_KW    = 12;

  localparam logic [5:0] KIND_END      = 6'd0;
  localparam logic [5:0] KIND_GT       = 6'd1;
  localparam logic [5:0] KIND_GE       = 6'd2;
  localparam logic [5:0] KIND_LT       = 6'd3;
  localparam logic [5:0] KIND_LE       = 6'd4;
  localparam logic [5:0] KIND_COLON    = 6'd5;
  localparam logic [5:0] KIND_DCOLON   = 6'd6;
  localparam logic [5:0] KIND_ASSIGN   = 6'd7;
  localparam logic [5:0] KIND_EQ       = 6'd8;
  localparam logic [5:0] KIND_MINUS    = 6'd9;
  localparam logic [5:0] KIND_SEMI     = 6'd10;
  localparam logic [5:0] KIND_COMMA    = 6'd11;
  localparam logic [5:0] KIND_DOT      = 6'd12;
  localparam logic [5:0] KIND_LBRACE   = 6'd13;
  localparam logic [5:0] KIND_LPAREN   = 6'd14;
  localparam logic [5:0] KIND_PLUS     = 6'd15;
  localparam logic [5:0] KIND_RBRACE   = 6'd16;
  localparam logic [5:0] KIND_RPAREN   = 6'd17;
  localparam logic [5:0] KIND_STAR     = 6'd18;
  localparam logic [5:0] KIND_CONST    = 6'd19;
  localparam logic [5:0] KIND_NAME     = 6'd20;
  localparam logic [5:0] KIND_CHUNK    = 6'd21;
  localparam logic [5:0] KIND_KW_BASE  = 6'd22;
  localparam logic [5:0] KIND_BAD      = 6'd34;
  localparam logic [5:0] KIND_OVERFLOW = 6'd35;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_GT, MODE_LT, MODE_COLON, MODE_EQ,
    MODE_MINUS, MODE_NUM, MODE_WORD, MODE_DEAD
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_PEND, ST_CHUNK_RD, ST_CHUNK_OUT, ST_FRESH, ST_END
  } state_t;

  typedef struct packed {
    logic accept;
    logic handled;
    logic pend;
    logic chunk_rd;
    logic chunk_out;
    logic fresh;
    logic finish;
  } ktl_cmd_t;

  typedef struct packed {
    logic eot;
    logic handled;
    logic handled_emit;
    logic pend_exists;
    logic pend_name;
    logic last_chunk;
    logic fresh_emit;
    logic out_free;
  } ktl_stat_t;

  function automatic logic is_numeral(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
  endfunction

  // keyword text, right-aligned, first character in the highest used byte
  function automatic logic [55:0] kw_text(input logic [3:0] k);
    case (k)
      4'd0:    return "assert";
      4'd1:    return "atomic";
      4'd2:    return "break";
      4'd3:    return "do";
      4'd4:    return "fi";
      4'd5:    return "goto";
      4'd6:    return "if";
      4'd7:    return "int";
      4'd8:    return "meta";
      4'd9:    return "od";
      4'd10:   return "process";
      4'd11:   return "skip";
      default: return '0;
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0, 4'd1:            return 3'd6;
      4'd2:                  return 3'd5;
      4'd3, 4'd4, 4'd6, 4'd9: return 3'd2;
      4'd5, 4'd8, 4'd11:     return 3'd4;
      4'd7:                  return 3'd3;
      4'd10:                 return 3'd7;
      default:               return 3'd0;
    endcase
  endfunction

endpackage

// ===== rtl/keyword_token_lexer_top.sv =====
// Streaming lexer: one source byte per input word (tlast marks the end of text instead of a
// byte). A byte that extends a word or a constant, completes a two-character operator, or is
// dropped after an error is handled in the decide step alone; other bytes also pass the fresh
// step, after a pend step if they close a pending token; a name adds a read and an output step
// per 8-character chunk (single read port of the row-wide name store); the end marker passes
// the end step, after a pend step for a pending token. Every cycle that loads a result waits
// while the output register holds an untaken word; the register lets the next byte be accepted
// while a result waits. Each token but the end token carries the line and column of its first
// character; tuser holds the token kind; tlast marks the final word caused by one input word.
module keyword_token_lexer_top #(
  parameter int MAX_WORD_CHARS = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] text_byte
  input  logic         s_tlast,   // end_of_text
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // token_value, name_chunk, token_line, token_column,
                                  // zero pad
  output logic [7:0]   m_tuser,   // token_kind, zero pad
  output logic         m_tlast    // last_of_run
);
  import ktl_pkg::*;

  ktl_cmd_t  cmd;
  ktl_stat_t st;

  ktl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ktl_dp #(.MAX_WORD_CHARS(MAX_WORD_CHARS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[5:0] <= KIND_OVERFLOW)) else $error("token kind out of range");
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[5:0] == KIND_END) |-> m_tlast) else $error("end token not last");
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[118:95] != 24'd0)) else $error("line zero");

endmodule

// ===== rtl/ktl_ctrl.sv =====
module ktl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ktl_pkg::ktl_stat_t st,
  output ktl_pkg::ktl_cmd_t  cmd
);
  import ktl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (st.eot) begin
          state_next = st.pend_exists ? ST_PEND : ST_END;
        end else if (st.handled) begin
          if (!st.handled_emit || st.out_free) state_next = ST_IDLE;
        end else begin
          state_next = st.pend_exists ? ST_PEND : ST_FRESH;
        end
      end
      ST_PEND: begin
        if (st.out_free) begin
          if (st.pend_name) state_next = ST_CHUNK_RD;
          else              state_next = st.eot ? ST_END : ST_FRESH;
        end
      end
      ST_CHUNK_RD: state_next = ST_CHUNK_OUT;
      ST_CHUNK_OUT: begin
        if (st.out_free) begin
          if (!st.last_chunk) state_next = ST_CHUNK_RD;
          else                state_next = st.eot ? ST_END : ST_FRESH;
        end
      end
      ST_FRESH: begin
        if (!st.fresh_emit || st.out_free) state_next = ST_IDLE;
      end
      ST_END: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_DECIDE:    cmd.handled   = !st.eot && st.handled && (!st.handled_emit || st.out_free);
      ST_PEND:      cmd.pend      = st.out_free;
      ST_CHUNK_RD:  cmd.chunk_rd  = 1'b1;
      ST_CHUNK_OUT: cmd.chunk_out = st.out_free;
      ST_FRESH:     cmd.fresh     = !st.fresh_emit || st.out_free;
      ST_END:       cmd.finish    = st.out_free;
      default: ;
    endcase
  end

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("second word taken mid-item");
  a_chunk_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHUNK_OUT) |-> ($past(state) == ST_CHUNK_RD || $past(state) == ST_CHUNK_OUT))
    else $error("chunk output without read");
  a_fresh_not_eot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FRESH) |-> !st.eot) else $error("fresh step on end marker");

endmodule

// ===== rtl/ktl_dp.sv =====
module ktl_dp #(
  parameter int MAX_WORD_CHARS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         s_tdata,
  input  logic               s_tlast,
  input  ktl_pkg::ktl_cmd_t  cmd,
  output ktl_pkg::ktl_stat_t st,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [135:0]       m_tdata,
  output logic [7:0]         m_tuser,
  output logic               m_tlast
);
  import ktl_pkg::*;

  localparam int LW   = $clog2(MAX_WORD_CHARS + 1);
  localparam int ROWS = (MAX_WORD_CHARS + 7) / 8;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [7:0]    in_byte;
  logic          in_eot;
  mode_t         mode;
  logic [30:0]   acc;
  logic [LW-1:0] word_length;
  logic [23:0]   line_count, start_line;
  logic [15:0]   column_count, start_column;
  logic [7:0]    kw_buf [8];
  logic [63:0]   mem [ROWS];
  logic [63:0]   rd_data;
  logic [RW-1:0] chunk_idx;

  logic [5:0]  o_kind;
  logic [30:0] o_value;
  logic [63:0] o_chunk;
  logic [23:0] o_line;
  logic [15:0] o_col;
  logic        o_valid, o_last;

  // byte classes
  logic dig, alp, sp, opc, out_free;
  logic [5:0] two_kind, punct_kind;
  logic [34:0] acc_next;
  logic ovf, word_room;
  logic [23:0] adv_line;
  logic [15:0] adv_col, end_col;

  assign dig       = is_numeral(in_byte);
  assign alp       = is_letter(in_byte);
  assign sp        = is_space(in_byte);
  assign opc       = (in_byte == ">") || (in_byte == "<") || (in_byte == ":") ||
                     (in_byte == "=") || (in_byte == "-");
  assign out_free  = !o_valid || m_tready;
  assign acc_next  = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + 35'(in_byte - "0");
  assign ovf       = acc_next > CONST_MAX;
  assign word_room = word_length < LW'(MAX_WORD_CHARS);
  assign adv_line  = (in_byte == 8'h0A && line_count != LINE_MAX) ? line_count + 24'd1
                                                                   : line_count;
  assign adv_col   = (in_byte == 8'h0A) ? 16'd0 :
                     (column_count != COL_MAX) ? column_count + 16'd1 : column_count;
  assign end_col   = (column_count != COL_MAX) ? column_count + 16'd1 : column_count;

  always_comb begin
    two_kind = KIND_END;
    case (mode)
      MODE_GT:    if (in_byte == "=") two_kind = KIND_GE;
      MODE_LT:    if (in_byte == "=") two_kind = KIND_LE;
      MODE_COLON: if (in_byte == ":") two_kind = KIND_DCOLON;
      MODE_EQ:    if (in_byte == "=") two_kind = KIND_EQ;
      MODE_MINUS: if (in_byte == ">") two_kind = KIND_SEMI;
      default: ;
    endcase
  end

  always_comb begin
    case (in_byte)
      ",":     punct_kind = KIND_COMMA;
      ".":     punct_kind = KIND_DOT;
      "{":     punct_kind = KIND_LBRACE;
      "(":     punct_kind = KIND_LPAREN;
      "+":     punct_kind = KIND_PLUS;
      "}":     punct_kind = KIND_RBRACE;
      ")":     punct_kind = KIND_RPAREN;
      ";":     punct_kind = KIND_SEMI;
      "*":     punct_kind = KIND_STAR;
      default: punct_kind = KIND_END;
    endcase
  end

  // keyword lookup on the first characters
  logic       kw_hit;
  logic [3:0] kw_idx;
  always_comb begin
    int          l;
    logic [55:0] txt;
    logic        m;
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      l   = int'(kw_len(4'(k)));
      txt = kw_text(4'(k));
      m   = (word_length == LW'(l));
      for (int i = 0; i < 7; i++) begin
        if (i < l) begin
          if (kw_buf[i] != txt[8*(l-1-i) +: 8]) m = 1'b0;
        end
      end
      if (m && !kw_hit) begin
        kw_hit = 1'b1;
        kw_idx = 4'(k);
      end
    end
  end

  logic [LW:0] chunk_base;
  logic [63:0] chunk_masked;
  assign chunk_base = (LW+1)'({chunk_idx, 3'b000});
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chunk_masked[8*i +: 8] = ((chunk_base + (LW+1)'(i)) < (LW+1)'(word_length))
                               ? rd_data[8*i +: 8] : 8'd0;
    end
  end

  assign st.eot          = in_eot;
  assign st.handled      = (two_kind != KIND_END) || (mode == MODE_NUM && dig) ||
                           (mode == MODE_WORD && (alp || dig)) || (mode == MODE_DEAD);
  assign st.handled_emit = (two_kind != KIND_END) || (mode == MODE_NUM && dig && ovf);
  assign st.pend_exists  = (mode != MODE_IDLE) && (mode != MODE_DEAD);
  assign st.pend_name    = (mode == MODE_WORD) && !kw_hit;
  assign st.last_chunk   = (chunk_base + (LW+1)'(8)) >= (LW+1)'(word_length);
  assign st.fresh_emit   = !sp && !opc && !dig && !alp;
  assign st.out_free     = out_free;

  // result selection
  logic        emit, e_last;
  logic [5:0]  e_kind;
  logic [30:0] e_value;
  logic [63:0] e_chunk;
  logic [23:0] e_line;
  logic [15:0] e_col;
  always_comb begin
    emit    = 1'b0;
    e_last  = 1'b1;
    e_kind  = KIND_END;
    e_value = '0;
    e_chunk = '0;
    e_line  = start_line;
    e_col   = start_column;
    if (cmd.handled) begin
      emit = st.handled_emit;
      if (two_kind != KIND_END) begin
        e_kind = two_kind;
      end else begin
        e_kind  = KIND_OVERFLOW;
        e_value = 31'(in_byte);
      end
    end else if (cmd.pend) begin
      emit   = 1'b1;
      e_last = !in_eot && !st.pend_name && !st.fresh_emit;
      case (mode)
        MODE_GT:    e_kind = KIND_GT;
        MODE_LT:    e_kind = KIND_LT;
        MODE_COLON: e_kind = KIND_COLON;
        MODE_EQ:    e_kind = KIND_ASSIGN;
        MODE_MINUS: e_kind = KIND_MINUS;
        MODE_NUM: begin
          e_kind  = KIND_CONST;
          e_value = acc;
        end
        default: begin
          if (kw_hit) begin
            e_kind = KIND_KW_BASE + 6'(kw_idx);
          end else begin
            e_kind  = KIND_NAME;
            e_value = 31'(word_length);
          end
        end
      endcase
    end else if (cmd.chunk_out) begin
      emit    = 1'b1;
      e_last  = st.last_chunk && !in_eot && !st.fresh_emit;
      e_kind  = KIND_CHUNK;
      e_chunk = chunk_masked;
    end else if (cmd.fresh) begin
      emit   = st.fresh_emit;
      e_line = adv_line;
      e_col  = adv_col;
      if (punct_kind != KIND_END) begin
        e_kind = punct_kind;
      end else begin
        e_kind  = KIND_BAD;
        e_value = 31'(in_byte);
      end
    end else if (cmd.finish) begin
      emit   = 1'b1;
      e_line = line_count;
      e_col  = end_col;
    end
  end

  // name store writes
  logic          wr_en;
  logic [RW-1:0] wr_row;
  logic [2:0]    wr_lane;
  always_comb begin
    wr_en   = 1'b0;
    wr_row  = '0;
    wr_lane = '0;
    if (cmd.handled && mode == MODE_WORD && word_room) begin
      wr_en   = 1'b1;
      wr_row  = RW'(word_length >> 3);
      wr_lane = word_length[2:0];
    end else if (cmd.fresh && !sp && !opc && !dig && alp && punct_kind == KIND_END) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][8*wr_lane +: 8] <= in_byte;
      if (word_length < LW'(8) || cmd.fresh) kw_buf[wr_lane] <= in_byte;
    end
    if (cmd.chunk_rd) rd_data <= mem[chunk_idx];
    if (cmd.accept) begin
      in_byte <= s_tdata;
      in_eot  <= s_tlast;
    end
    if (emit) begin
      o_kind  <= e_kind;
      o_value <= e_value;
      o_chunk <= e_chunk;
      o_line  <= e_line;
      o_col   <= e_col;
      o_last  <= e_last;
    end
    if (cmd.pend)      chunk_idx <= '0;
    if (cmd.chunk_out) chunk_idx <= chunk_idx + RW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid      <= 1'b0;
      mode         <= MODE_IDLE;
      acc          <= '0;
      word_length  <= '0;
      line_count   <= 24'd1;
      column_count <= '0;
      start_line   <= 24'd1;
      start_column <= '0;
    end else begin
      if (emit)          o_valid <= 1'b1;
      else if (m_tready) o_valid <= 1'b0;

      if (cmd.handled) begin
        line_count   <= adv_line;
        column_count <= adv_col;
        if (two_kind != KIND_END) begin
          mode <= MODE_IDLE;
        end else if (mode == MODE_NUM) begin
          if (ovf) mode <= MODE_DEAD;
          else     acc  <= acc_next[30:0];
        end else if (mode == MODE_WORD && word_room) begin
          word_length <= word_length + LW'(1);
        end
      end
      if (cmd.pend) mode <= MODE_IDLE;
      if (cmd.fresh) begin
        line_count   <= adv_line;
        column_count <= adv_col;
        if (!sp) begin
          start_line   <= adv_line;
          start_column <= adv_col;
          if      (in_byte == ">") mode <= MODE_GT;
          else if (in_byte == "<") mode <= MODE_LT;
          else if (in_byte == ":") mode <= MODE_COLON;
          else if (in_byte == "=") mode <= MODE_EQ;
          else if (in_byte == "-") mode <= MODE_MINUS;
          else if (punct_kind != KIND_END) mode <= MODE_IDLE;
          else if (dig) begin
            acc  <= 31'(in_byte - "0");
            mode <= MODE_NUM;
          end else if (alp) begin
            word_length <= LW'(1);
            mode        <= MODE_WORD;
          end else begin
            mode <= MODE_DEAD;
          end
        end
      end
      if (cmd.finish) begin
        mode         <= MODE_IDLE;
        acc          <= '0;
        word_length  <= '0;
        line_count   <= 24'd1;
        column_count <= '0;
        start_line   <= 24'd1;
        start_column <= '0;
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_tlast  = o_last;
  assign m_tdata  = {1'b0, o_col, o_line, o_chunk, o_value};
  assign m_tuser  = {2'd0, o_kind};

endmodule
